FILE: sv/bba_pkg.sv
// Shared types, codes and helper functions of the buddy block allocator.
`default_nettype none

package bba_pkg;

    localparam int unsigned LEVELS_DEF = 10;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned REQ_W    = 16;
    localparam int unsigned OFF_W    = 10;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SIZE_W   = 11;
    // A rounded request of up to 2^16-1 units needs a level value of up to 17.
    localparam int unsigned NEED_W   = 5;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REQ_W-1:0]  request_size;
        logic [OFF_W-1:0]  offset;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    block_offset;
        logic [SIZE_W-1:0]   block_size;
    } t_resp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT,
        S_DESC,
        S_MARK,
        S_FIND,
        S_CLIMB,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_ACCEPT,
        CMD_FAIL_SHORT,
        CMD_READ_LEFT,
        CMD_DESCEND,
        CMD_MARK,
        CMD_FOUND_QUERY,
        CMD_FOUND_FREE,
        CMD_UP,
        CMD_CLIMB,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic in_alloc;
        logic in_bad;
        logic rd_short;
        logic at_need;
        logic desc_last;
        logic rd_zero;
        logic at_root;
        logic parent_root;
        logic clear_last;
        logic is_query;
    } t_dp_status;

    // Level value of the smallest power-of-two block holding req units.
    function automatic logic [NEED_W-1:0] need_of(input logic [REQ_W-1:0] req);
        logic [REQ_W-1:0]  v;
        logic [NEED_W-1:0] k;
        v = (req == '0) ? '0 : req - REQ_W'(1);
        k = '0;
        for (int i = 0; i < REQ_W; i++) begin
            if (v[i]) begin
                k = NEED_W'(i + 1);
            end
        end
        return k + NEED_W'(1);
    endfunction

endpackage

`default_nettype wire

FILE: sv/bba_chan.sv
// Valid/ready channel interface carrying one payload per transaction.
`default_nettype none

interface bba_chan #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: sv/buddy_block_allocator_core.sv
// Top level of the buddy block allocator: controller, datapath and channel ports.
//
//  Channel   Direction  Payload                                     Handshake
//  i_req     in         kind, request_size, offset                  valid/ready
//  o_resp    out        status, block_offset, block_size            valid/ready
//
// Each operation walks the tree held in one memory with one read and one write
// port, one tree level per cycle. After reset a clearing pass writes every node
// of the tree, one per cycle; i_req.ready stays low until it is over.
// The result sits in an output register, so a stalled o_resp does not stop the
// next transaction being taken; the walk of that next item then only waits at
// its final step until the previous result has been taken.
`default_nettype none

module buddy_block_allocator_core #(
    parameter int unsigned LEVELS = bba_pkg::LEVELS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    bba_chan.sink   i_req,
    bba_chan.source o_resp
);
    import bba_pkg::*;

    t_cmd       cmd;
    t_dp_status status;
    t_resp      resp_data;
    logic       in_ready;
    logic       out_valid;

    // The controller sequences the walk: clearing, descent for an allocate,
    // the climb to the owning node for a free or query, then the climb that
    // rebuilds the maxima up to the root.
    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_resp.ready),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // The datapath holds the tree, the walk registers and the result.
    bba_datapath #(
        .LEVELS (LEVELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req_data  (i_req.payload),
        .o_status    (status),
        .o_resp_data (resp_data)
    );

    assign i_req.ready    = in_ready;
    assign o_resp.valid   = out_valid;
    assign o_resp.payload = resp_data;

    // Once a transaction is taken the block is busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("input taken again straight after a transaction");

    // A result appears only from the final step of a walk, never while idle.
    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_resp.valid) |-> $past(!i_req.ready))
        else $error("result appeared while the block was idle");

    // A granted block starts on a multiple of its own size.
    a_aligned_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp.valid && o_resp.payload.status == ST_OK &&
         o_resp.payload.block_size != '0) |->
        ((SIZE_W'(o_resp.payload.block_offset) &
          (o_resp.payload.block_size - SIZE_W'(1))) == '0))
        else $error("granted block is not aligned to its size");

    // Error results carry no offset and no size.
    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp.valid && (o_resp.payload.status == ST_NO_SPACE ||
                          o_resp.payload.status == ST_NOT_ALLOC)) |->
        (o_resp.payload.block_offset == '0 && o_resp.payload.block_size == '0))
        else $error("error result carries a block");

endmodule

`default_nettype wire

FILE: sv/bba_datapath.sv
// Datapath of the buddy allocator: tree memory, walk registers and result registers.
`default_nettype none

module bba_datapath #(
    parameter int unsigned LEVELS = bba_pkg::LEVELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bba_pkg::t_cmd      i_cmd,
    input  bba_pkg::t_req      i_req_data,
    output bba_pkg::t_dp_status o_status,
    output bba_pkg::t_resp     o_resp_data
);
    import bba_pkg::*;

    localparam int unsigned NW    = LEVELS + 1;
    localparam int unsigned LW    = $clog2(LEVELS + 2);
    localparam int unsigned DEPTH = 1 << NW;
    localparam int unsigned CMP_W = (LW > NEED_W) ? LW : NEED_W;
    localparam int unsigned XW    = ((NW + 1) > (OFF_W + 1)) ? (NW + 1) : (OFF_W + 1);
    localparam int unsigned BW    = NW + OFF_W;

    logic [LW-1:0] mem [DEPTH];

    logic [NW-1:0]     r_node, n_node;
    logic [LW-1:0]     r_lvl, n_lvl;
    logic [LW-1:0]     r_val, n_val;
    logic [NEED_W-1:0] r_need, n_need;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic              r_merge, n_merge;
    logic [LW-1:0]     r_rdata;
    t_resp             r_res, n_res;
    t_resp             r_out, n_out;

    logic              we;
    logic [NW-1:0]     waddr;
    logic [LW-1:0]     wdata;
    logic [NW-1:0]     rd_addr;

    logic [NEED_W-1:0] need_in;
    logic [CMP_W-1:0]  lvl_ext, need_ext, rd_ext;
    logic [XW-1:0]     leaf_ext;
    logic              off_out;
    logic [NW-1:0]     leaf, sibling, parent, child;
    logic [LW-1:0]     max_v, parent_v;
    logic [SIZE_W-1:0] size_cur;
    logic [BW-1:0]     boff_w;

    assign need_in  = need_of(i_req_data.request_size);
    assign lvl_ext  = CMP_W'(r_lvl);
    assign need_ext = CMP_W'(r_need);
    assign rd_ext   = CMP_W'(r_rdata);

    assign off_out  = XW'(i_req_data.offset) >= (XW'(1) << LEVELS);
    assign leaf_ext = (XW'(1) << LEVELS) | XW'(i_req_data.offset);
    assign leaf     = leaf_ext[NW-1:0];

    assign sibling  = r_node ^ NW'(1);
    assign parent   = {1'b0, r_node[NW-1:1]};
    assign child    = {r_node[NW-2:0], rd_ext < need_ext};

    assign max_v    = (r_val > r_rdata) ? r_val : r_rdata;
    // Two wholly free buddies of the child level merge into one parent block.
    assign parent_v = (r_merge && r_val == r_rdata && r_rdata == r_lvl) ?
                      r_lvl + LW'(1) : max_v;

    assign size_cur = SIZE_W'(1) << (r_lvl - LW'(1));
    assign boff_w   = (BW'(r_node) << (r_lvl - LW'(1))) &
                      ((BW'(1) << LEVELS) - BW'(1));

    assign o_status.in_alloc    = i_req_data.kind == KIND_ALLOC;
    assign o_status.in_bad      = !(i_req_data.kind == KIND_FREE ||
                                    i_req_data.kind == KIND_QUERY) || off_out;
    assign o_status.rd_short    = rd_ext < need_ext;
    assign o_status.at_need     = lvl_ext == need_ext;
    assign o_status.desc_last   = lvl_ext == (need_ext + CMP_W'(1));
    assign o_status.rd_zero     = r_rdata == '0;
    assign o_status.at_root     = r_node == NW'(1);
    assign o_status.parent_root = r_node[NW-1:1] == (NW - 1)'(1);
    assign o_status.clear_last  = &r_node;
    assign o_status.is_query    = r_kind == KIND_QUERY;

    assign o_resp_data = r_out;

    always_comb begin
        n_node  = r_node;
        n_lvl   = r_lvl;
        n_val   = r_val;
        n_need  = r_need;
        n_kind  = r_kind;
        n_merge = r_merge;
        n_res   = r_res;
        n_out   = r_out;
        we      = 1'b0;
        waddr   = r_node;
        wdata   = r_lvl;
        rd_addr = r_node;
        unique case (i_cmd)
            CMD_NONE: begin
            end
            CMD_CLEAR: begin
                we     = 1'b1;
                n_node = r_node + NW'(1);
                if (((r_node + NW'(1)) & r_node) == '0) begin
                    n_lvl = r_lvl - LW'(1);
                end
            end
            CMD_ACCEPT: begin
                n_kind  = i_req_data.kind;
                n_need  = need_in;
                n_merge = 1'b0;
                n_res   = '{status: ST_NOT_ALLOC, block_offset: '0, block_size: '0};
                if (i_req_data.kind == KIND_ALLOC) begin
                    n_node  = NW'(1);
                    n_lvl   = LW'(LEVELS + 1);
                    rd_addr = NW'(1);
                end else begin
                    n_node  = leaf;
                    n_lvl   = LW'(1);
                    rd_addr = leaf;
                end
            end
            CMD_FAIL_SHORT: begin
                n_res = '{status: ST_NO_SPACE, block_offset: '0, block_size: '0};
            end
            CMD_READ_LEFT: begin
                rd_addr = {r_node[NW-2:0], 1'b0};
            end
            CMD_DESCEND: begin
                n_node  = child;
                n_lvl   = r_lvl - LW'(1);
                rd_addr = {child[NW-2:0], 1'b0};
            end
            CMD_MARK: begin
                we      = 1'b1;
                wdata   = '0;
                n_val   = '0;
                rd_addr = sibling;
                n_res   = '{status: ST_OK, block_offset: boff_w[OFF_W-1:0],
                            block_size: size_cur};
            end
            CMD_FOUND_QUERY: begin
                n_res = '{status: ST_OK, block_offset: '0, block_size: size_cur};
            end
            CMD_FOUND_FREE: begin
                we      = 1'b1;
                n_val   = r_lvl;
                n_merge = 1'b1;
                rd_addr = sibling;
                n_res   = '{status: ST_OK, block_offset: '0, block_size: size_cur};
            end
            CMD_UP: begin
                n_node  = parent;
                n_lvl   = r_lvl + LW'(1);
                rd_addr = parent;
            end
            CMD_CLIMB: begin
                we      = 1'b1;
                waddr   = parent;
                wdata   = parent_v;
                n_val   = parent_v;
                n_node  = parent;
                n_lvl   = r_lvl + LW'(1);
                rd_addr = parent ^ NW'(1);
            end
            CMD_EMIT: begin
                n_out = r_res;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= NW'(1);
            r_lvl  <= LW'(LEVELS + 1);
        end else begin
            r_node <= n_node;
            r_lvl  <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_need  <= n_need;
        r_kind  <= n_kind;
        r_merge <= n_merge;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

FILE: sv/bba_ctrl.sv
// Controller state machine of the buddy allocator.
`default_nettype none

module bba_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  bba_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output bba_pkg::t_cmd       o_cmd
);
    import bba_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   emit;

    assign emit = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_status.in_alloc) n_state = S_ROOT;
                    else if (i_status.in_bad)       n_state = S_DONE;
                    else                            n_state = S_FIND;
                end
            end
            S_ROOT: begin
                priority if (i_status.rd_short) n_state = S_DONE;
                else if (i_status.at_need)      n_state = S_MARK;
                else                            n_state = S_DESC;
            end
            S_DESC: begin
                if (i_status.desc_last) n_state = S_MARK;
            end
            S_MARK: begin
                n_state = i_status.at_root ? S_DONE : S_CLIMB;
            end
            S_FIND: begin
                priority if (i_status.rd_zero) begin
                    if (i_status.is_query || i_status.at_root) n_state = S_DONE;
                    else                                       n_state = S_CLIMB;
                end else if (i_status.at_root) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FIND;
                end
            end
            S_CLIMB: begin
                if (i_status.parent_root) n_state = S_DONE;
            end
            S_DONE: begin
                if (emit) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd = CMD_CLEAR;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = CMD_ACCEPT;
            end
            S_ROOT: begin
                priority if (i_status.rd_short) o_cmd = CMD_FAIL_SHORT;
                else if (i_status.at_need)      o_cmd = CMD_NONE;
                else                            o_cmd = CMD_READ_LEFT;
            end
            S_DESC:  o_cmd = CMD_DESCEND;
            S_MARK:  o_cmd = CMD_MARK;
            S_FIND: begin
                priority if (i_status.rd_zero) begin
                    o_cmd = i_status.is_query ? CMD_FOUND_QUERY : CMD_FOUND_FREE;
                end else if (!i_status.at_root) begin
                    o_cmd = CMD_UP;
                end else begin
                    o_cmd = CMD_NONE;
                end
            end
            S_CLIMB: o_cmd = CMD_CLIMB;
            S_DONE: begin
                if (emit) o_cmd = CMD_EMIT;
            end
            default: o_cmd = CMD_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (emit)    n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire
